FILE: design/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and CRC helpers for the Modbus RTU request framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mrf_pkg;

  localparam logic [7:0]  FC_READ    = 8'h03;
  localparam logic [7:0]  FC_WRITE   = 8'h06;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_RESET  = 16'hFFFF;
  localparam int          FRAME_LEN  = 8;
  localparam int          BODY_LEN   = 6;
  localparam int          IDX_W      = $clog2(FRAME_LEN);
  localparam int          S_DATA_W   = 56;
  localparam int          M_DATA_W   = 8;

  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(BODY_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic [15:0]     crc_init;
    logic [5:0][7:0] body;
  } frame_req_t;

  // Table entry of the reflected CRC-16 (entry 1 is 0xC0C1).
  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ crc_table(crc[7:0] ^ b);
  endfunction

endpackage

`default_nettype wire

FILE: design/modbus_request_framer_crc16_top.sv
// ----------------------------------------------------------------------------
// modbus_request_framer_crc16_top
// Modbus RTU request framer: one request word in, eight frame bytes out.
// ----------------------------------------------------------------------------
// Each request word becomes an 8-byte RTU frame on the master side: address,
// function code (0x03 read, 0x06 write), register address, count or value,
// then the CRC-16 low and high byte, with tlast on the last. The master side
// moves one byte per clock while m_tready is high. A two-entry queue sits
// between the request side and the byte sender, so new requests are taken
// while a frame is still going out. On an idle block, a request is written
// into the queue, then loaded into the sender's request register, and its
// first byte is then registered onto the master side.
`default_nettype none

module modbus_request_framer_crc16_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // device_address[7:0], register_address[23:8], read_count[39:24],
  // write_value[55:40]
  input  wire logic [mrf_pkg::S_DATA_W-1:0]  s_tdata,
  // action[0]
  input  wire logic [0:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // frame_byte[7:0]
  output logic [mrf_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                               m_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [15:0]                   cfg_data
);

  mrf_pkg::frame_req_t wr_data;
  mrf_pkg::frame_req_t rd_data;
  logic                q_wr;
  logic                q_ready;
  logic                q_rd;
  logic                q_valid;

  mrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_wr      (q_wr),
    .q_ready   (q_ready),
    .q_data    (wr_data)
  );

  mrf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_ready (q_ready),
    .wr_data  (wr_data),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_data  (rd_data)
  );

  mrf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_rd     (q_rd),
    .q_data   (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

FILE: design/mrf_front.sv
// ----------------------------------------------------------------------------
// mrf_front
// Accepts request words, holds the CRC start register and builds frame bodies.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [mrf_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic [0:0]                    s_tuser,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [15:0]                   cfg_data,
  output logic                               q_wr,
  input  wire logic                          q_ready,
  output mrf_pkg::frame_req_t                q_data
);

  logic [15:0] crc_start;
  logic [7:0]  device_address;
  logic [15:0] register_address;
  logic [15:0] read_count;
  logic [15:0] write_value;
  logic [15:0] operand;
  logic [7:0]  func_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_start <= mrf_pkg::CRC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      crc_start <= cfg_data;
    end
  end

  assign device_address   = s_tdata[7:0];
  assign register_address = s_tdata[23:8];
  assign read_count       = s_tdata[39:24];
  assign write_value      = s_tdata[55:40];

  assign operand   = s_tuser[0] ? write_value : read_count;
  assign func_code = s_tuser[0] ? mrf_pkg::FC_WRITE : mrf_pkg::FC_READ;

  assign s_tready = q_ready;
  assign q_wr     = s_tvalid && q_ready;

  always_comb begin
    q_data.crc_init = crc_start;
    q_data.body[0]  = device_address;
    q_data.body[1]  = func_code;
    q_data.body[2]  = register_address[15:8];
    q_data.body[3]  = register_address[7:0];
    q_data.body[4]  = operand[15:8];
    q_data.body[5]  = operand[7:0];
  end

endmodule

`default_nettype wire

FILE: design/mrf_queue.sv
// ----------------------------------------------------------------------------
// mrf_queue
// Two-entry queue of frame requests between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr,
  output logic                     wr_ready,
  input  wire mrf_pkg::frame_req_t wr_data,
  input  wire logic                rd,
  output logic                     rd_valid,
  output mrf_pkg::frame_req_t      rd_data
);

  mrf_pkg::frame_req_t mem [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && wr_ready) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && wr_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd && rd_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr && wr_ready, rd && rd_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/mrf_back.sv
// ----------------------------------------------------------------------------
// mrf_back
// Sends one frame byte per word, folding each body byte into the CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_rd,
  input  wire mrf_pkg::frame_req_t           q_data,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [mrf_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                               m_tlast
);

  mrf_pkg::frame_req_t      req;
  logic                     busy;
  logic [mrf_pkg::IDX_W-1:0] idx;
  logic [15:0]              crc;
  logic [7:0]               byte_sel;
  logic                     advance;
  logic                     at_last;

  assign advance = !m_tvalid || m_tready;
  assign at_last = (idx == mrf_pkg::IDX_LAST);
  assign q_rd    = q_valid && (!busy || (advance && at_last));

  always_comb begin
    case (idx)
      3'd0:    byte_sel = req.body[0];
      3'd1:    byte_sel = req.body[1];
      3'd2:    byte_sel = req.body[2];
      3'd3:    byte_sel = req.body[3];
      3'd4:    byte_sel = req.body[4];
      3'd5:    byte_sel = req.body[5];
      3'd6:    byte_sel = crc[7:0];
      default: byte_sel = crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (advance) begin
        m_tvalid <= busy;
        if (busy) begin
          m_tdata <= byte_sel;
          m_tlast <= at_last;
          if (idx < mrf_pkg::IDX_CRC_LO) begin
            crc <= mrf_pkg::crc_update(crc, byte_sel);
          end
        end
      end
      if (q_rd) begin
        req  <= q_data;
        crc  <= q_data.crc_init;
        idx  <= '0;
        busy <= 1'b1;
      end else if (advance && busy) begin
        idx <= idx + 3'd1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/mrf_checker.sv
// ----------------------------------------------------------------------------
// mrf_checker
// Port-level checks on frame length, function codes, pending requests and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [mrf_pkg::M_DATA_W-1:0]  m_tdata,
  input wire logic                          m_tlast
);

  logic [mrf_pkg::IDX_W-1:0] pos;
  logic [2:0]                pending;
  logic                      in_acc;
  logic                      out_acc;
  logic                      frame_done;

  assign in_acc     = s_tvalid && s_tready;
  assign out_acc    = m_tvalid && m_tready;
  assign frame_done = out_acc && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pending <= '0;
    end else begin
      if (out_acc) begin
        pos <= pos + 3'd1;
      end
      case ({in_acc, frame_done})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_tlast_on_eighth: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (m_tlast == (pos == mrf_pkg::IDX_LAST)))
    else $error("tlast not on eighth byte of frame");

  a_func_code: assert property (@(posedge clk) disable iff (rst)
    (out_acc && pos == 3'd1) |->
      (m_tdata == mrf_pkg::FC_READ || m_tdata == mrf_pkg::FC_WRITE))
    else $error("bad function code byte");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pending != 3'd0))
    else $error("output word without pending request");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output word changed");

endmodule

bind modbus_request_framer_crc16_top mrf_checker u_mrf_checker (.*);

`default_nettype wire
